// File: rtl/sst_pkg.sv
// shared types and constants of the sorted score table
package sst_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned ScoreW        = 31;
  localparam int unsigned KillsW        = 16;
  localparam int unsigned PlayerW       = 32;
  localparam int unsigned IndexW        = 6;
  localparam int unsigned CountOutW     = 7;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRead   = 1'b1;

  typedef struct packed {
    logic                       operation;
    logic signed [31:0]         new_score;
    logic        [KillsW-1:0]   new_kills;
    logic        [PlayerW-1:0]  new_player;
    logic        [IndexW-1:0]   entry_index;
  } in_word_t;

  typedef struct packed {
    logic [ScoreW-1:0]    entry_score;
    logic [KillsW-1:0]    entry_kills;
    logic [PlayerW-1:0]   entry_player;
    logic                 entry_valid;
    logic                 accepted;
    logic [CountOutW-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic [ScoreW-1:0]  score;
    logic [KillsW-1:0]  kills;
    logic [PlayerW-1:0] player;
  } rec_t;

  typedef enum logic [2:0] {
    StIdle,
    StChkFull,
    StShift,
    StPlace,
    StRdWait
  } state_e;

endpackage

// File: rtl/sorted_score_table_top.sv
// sorted score table: top level with insert/read sequencer and result register
//
// Holds up to TableDepth records (score, kills, player) in one memory, highest
// score first; equal scores keep arrival order. A read registers the memory word
// and then loads it into the result register. An insert walks the table from the
// tail toward the head, moving one entry per cycle through the single memory
// write port, and first checks the lowest entry when the table is full. Negative
// scores and inserts into a full table whose score is not above the lowest entry
// return accepted = 0 with the table unchanged; negative scores are answered
// from the idle state. A stalled result word holds the sequencer before its last
// step. The input is stalled while an item is in work or the result word is
// stalled. No clearing pass after reset.
module sorted_score_table_top #(
  parameter int unsigned TableDepth = sst_pkg::TableDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sst_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sst_pkg::out_word_t out_word_o
);
  import sst_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned IW = (CW > IndexW) ? CW : IndexW;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;
  rec_t          new_q, new_d;
  logic          rdok_q, rdok_d;
  out_word_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;

  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;
  logic          re;
  logic [AW-1:0] raddr;
  rec_t          rdata;

  logic          in_fire;
  logic          fin_ok;
  rec_t          in_rec;

  sst_table #(.Depth(TableDepth)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign fin_ok     = !out_valid_q || !out_stall_i;
  assign in_rec     = '{score:  in_word_i.new_score[ScoreW-1:0],
                        kills:  in_word_i.new_kills,
                        player: in_word_i.new_player};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    new_d    = new_q;
    rdok_d   = rdok_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = new_q;
    re       = 1'b0;
    raddr    = '0;
    out_load = 1'b0;
    out_d    = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_word_i.operation == OpRead) begin
            re      = 1'b1;
            raddr   = AW'(in_word_i.entry_index);
            rdok_d  = IW'(in_word_i.entry_index) < IW'(count_q);
            state_d = StRdWait;
          end else if (in_word_i.new_score[31]) begin
            out_load          = 1'b1;
            out_d.entry_count = CountOutW'(count_q);
          end else begin
            new_d = in_rec;
            if (count_q == CW'(TableDepth)) begin
              re      = 1'b1;
              raddr   = AW'(TableDepth - 1);
              state_d = StChkFull;
            end else if (count_q == '0) begin
              we                = 1'b1;
              waddr             = '0;
              wdata             = in_rec;
              count_d           = CW'(1);
              out_load          = 1'b1;
              out_d.accepted    = 1'b1;
              out_d.entry_count = CountOutW'(1);
            end else begin
              pos_d   = AW'(count_q);
              re      = 1'b1;
              raddr   = AW'(count_q - CW'(1));
              state_d = StShift;
            end
          end
        end
      end
      StChkFull: begin
        if (new_q.score <= rdata.score) begin
          if (fin_ok) begin
            out_load          = 1'b1;
            out_d.entry_count = CountOutW'(count_q);
            state_d           = StIdle;
          end
        end else begin
          count_d = CW'(TableDepth - 1);
          pos_d   = AW'(TableDepth - 1);
          re      = 1'b1;
          raddr   = AW'(TableDepth - 2);
          state_d = StShift;
        end
      end
      StShift: begin
        if (rdata.score >= new_q.score) begin
          if (fin_ok) begin
            we                = 1'b1;
            count_d           = CW'(count_q + CW'(1));
            out_load          = 1'b1;
            out_d.accepted    = 1'b1;
            out_d.entry_count = CountOutW'(count_q + CW'(1));
            state_d           = StIdle;
          end
        end else begin
          we    = 1'b1;
          wdata = rdata;
          pos_d = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = StPlace;
          end else begin
            re    = 1'b1;
            raddr = pos_q - AW'(2);
          end
        end
      end
      StPlace: begin
        if (fin_ok) begin
          we                = 1'b1;
          count_d           = CW'(count_q + CW'(1));
          out_load          = 1'b1;
          out_d.accepted    = 1'b1;
          out_d.entry_count = CountOutW'(count_q + CW'(1));
          state_d           = StIdle;
        end
      end
      StRdWait: begin
        if (fin_ok) begin
          out_load          = 1'b1;
          out_d.entry_count = CountOutW'(count_q);
          if (rdok_q) begin
            out_d.entry_score  = rdata.score;
            out_d.entry_kills  = rdata.kills;
            out_d.entry_player = rdata.player;
            out_d.entry_valid  = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    new_q  <= new_d;
    rdok_q <= rdok_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TableDepth))
    else $error("record count above table depth");

  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StShift |-> (pos_q != '0) && (CW'(pos_q) <= count_q))
    else $error("shift position out of range");

  a_acc_rd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.accepted && out_q.entry_valid))
    else $error("result word flags both insert and read");

  a_acc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_d.accepted |=> count_q != '0)
    else $error("accepted insert left table empty");

endmodule

// File: rtl/sst_table.sv
// record memory: one write port, one registered read port
module sst_table #(
  parameter int unsigned Depth = sst_pkg::TableDepthDef
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(Depth)-1:0]     waddr_i,
  input  sst_pkg::rec_t                wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(Depth)-1:0]     raddr_i,
  output sst_pkg::rec_t                rdata_o
);
  import sst_pkg::*;

  rec_t mem [Depth];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: dv/sst_score_checker.sv
// score table checker: watches both channels, predicts each result word and compares it
module sst_score_checker #(
  parameter int unsigned TableDepth = sst_pkg::TableDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sst_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sst_pkg::out_word_t out_word_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  rec_t        ranking [TableDepth];
  int unsigned held;
  out_word_t   awaited_results [$];

  function automatic out_word_t ranked_result(in_word_t w);
    out_word_t         r;
    logic [ScoreW-1:0] s;
    int unsigned       pos;
    int                i;
    r = '0;
    s = w.new_score[ScoreW-1:0];
    if (w.operation == OpInsert) begin
      if (!w.new_score[31] && (held < TableDepth || s > ranking[TableDepth-1].score)) begin
        // full table drops its lowest entry
        if (held >= TableDepth) held = TableDepth - 1;
        pos = 0;
        while (pos < held && ranking[pos].score >= s) pos++;
        for (i = held; i > pos; i--) ranking[i] = ranking[i-1];
        ranking[pos].score  = s;
        ranking[pos].kills  = w.new_kills;
        ranking[pos].player = w.new_player;
        held++;
        r.accepted = 1'b1;
      end
    end else if (w.entry_index < held) begin
      r.entry_score  = ranking[w.entry_index].score;
      r.entry_kills  = ranking[w.entry_index].kills;
      r.entry_player = ranking[w.entry_index].player;
      r.entry_valid  = 1'b1;
    end
    r.entry_count = CountOutW'(held);
    return r;
  endfunction

  function automatic int field_err(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_word_t want;
    out_word_t predicted;
    if (!rst_ni) begin
      held = 0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %h", $time, out_word_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          fail_count_o += field_err("entry_score", want.entry_score, out_word_i.entry_score)
                        + field_err("entry_kills", want.entry_kills, out_word_i.entry_kills)
                        + field_err("entry_player", want.entry_player, out_word_i.entry_player)
                        + field_err("entry_valid", want.entry_valid, out_word_i.entry_valid)
                        + field_err("accepted", want.accepted, out_word_i.accepted)
                        + field_err("entry_count", want.entry_count, out_word_i.entry_count);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted = ranked_result(in_word_i);
        awaited_results = {awaited_results, predicted};
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// File: dv/tb_sorted_score_table_top.sv
// testbench top of the sorted score table: clock, reset, stimulus, idling and verdict
module tb_sorted_score_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int unsigned CycleLimit  = 4_000_000;
  localparam int unsigned RandomWords = 1430;
  localparam int unsigned DrainCycles = TableDepthDef + 8;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_word_t    in_word   = '0;
  logic        out_stall = 1'b0;
  logic        hold_off  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_word_t   out_word;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_sent = 0;
  int unsigned tx_quiet   = 0;
  int unsigned cycle_cnt  = 0;
  logic [ScoreW-1:0] seen_scores [$];

  always #2 clk_i = ~clk_i;

  sorted_score_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  sst_score_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_word_t ins_word(logic [31:0] score, logic [KillsW-1:0] kills,
                                        logic [PlayerW-1:0] player);
    in_word_t w;
    w.operation   = OpInsert;
    w.new_score   = score;
    w.new_kills   = kills;
    w.new_player  = player;
    w.entry_index = IndexW'($urandom);
    return w;
  endfunction

  function automatic in_word_t rd_word(logic [IndexW-1:0] idx);
    in_word_t w;
    w.operation   = OpRead;
    w.new_score   = $urandom;
    w.new_kills   = KillsW'($urandom);
    w.new_player  = $urandom;
    w.entry_index = idx;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (tx_quiet > 0) begin
      tx_quiet--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) tx_quiet = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
  endtask

  initial begin : rx_drive
    int unsigned stall_left;
    int unsigned quiet_left;
    stall_left = 0;
    quiet_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (quiet_left > 0) quiet_left--;
      else if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 59) == 0) quiet_left = $urandom_range(50, 200);
      else stall_left = pick_gap();
      out_stall <= hold_off || stall_left > 0;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : long_hold
    int unsigned held_cycles;
    wait (words_sent >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    for (held_cycles = 0; held_cycles < 400; held_cycles++) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    in_word_t    w;
    int unsigned n;
    int unsigned pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(rd_word(6'd0));
    send_word(rd_word(6'd63));
    send_word(ins_word(32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(ins_word(32'hFFFF_FFFF, 16'h0001, 32'h0000_0001));
    send_word(ins_word(32'h0000_0000, 16'h0000, 32'h0000_0000));
    send_word(ins_word(32'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(ins_word(32'd100, 16'd11, 32'd1));
    send_word(ins_word(32'd100, 16'd12, 32'd2));
    send_word(ins_word(32'd100, 16'd13, 32'd3));
    send_word(ins_word(32'd0, 16'd14, 32'd4));
    send_word(ins_word(32'd50, 16'd15, 32'd5));
    send_word(ins_word(32'h7FFF_FFFF, 16'h0000, 32'h0000_0006));
    for (n = 0; n < 9; n++) send_word(rd_word(IndexW'(n)));
    send_word(rd_word(6'd63));

    for (n = 0; n < RandomWords; n++) begin
      w.operation   = ($urandom_range(0, 9) < 4) ? OpRead : OpInsert;
      w.new_kills   = ($urandom_range(0, 7) == 0) ? {KillsW{$urandom_range(0, 1) == 1}}
                                                  : KillsW'($urandom);
      w.new_player  = $urandom;
      w.entry_index = IndexW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10) w.new_score = {1'b1, 31'($urandom)};
      else if (pick < 30 && seen_scores.size() > 0)
        w.new_score = {1'b0, seen_scores[$urandom_range(0, seen_scores.size() - 1)]};
      else if (pick < 55) w.new_score = $urandom_range(0, 20);
      else if (pick < 62) w.new_score = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
      else w.new_score = {1'b0, 31'($urandom)};
      if (w.operation == OpInsert && !w.new_score[31]) begin
        seen_scores = {seen_scores, w.new_score[ScoreW-1:0]};
        if (seen_scores.size() > TableDepthDef) void'(seen_scores.pop_front());
      end
      send_word(w);
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
